// File: hw/rtl/bcld_pkg.sv
// Package for the button click and long-press detector.
// Holds the mode and event codes, configuration register indexes and reset values.
// No dependencies.
package bcld_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_DOWN      = 3'd1,
        MODE_UP        = 3'd2,
        MODE_COUNT     = 3'd3,
        MODE_PRESS     = 3'd4,
        MODE_PRESS_END = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_SINGLE = 3'd1,
        EV_DOUBLE = 3'd2,
        EV_MULTI  = 3'd3,
        EV_LSTART = 3'd4,
        EV_DURING = 3'd5,
        EV_LSTOP  = 3'd6
    } event_t;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE     = 2'd0,
        CFG_CLICK_WINDOW = 2'd1,
        CFG_LONG_PRESS   = 2'd2,
        CFG_MAX_CLICKS   = 2'd3
    } cfg_index_t;

    localparam int CFG_DATA_W = 16;
    localparam int TIME_W     = 32;
    localparam int CLICK_W    = 4;

    localparam logic [15:0]        DEBOUNCE_RESET     = 16'd50;
    localparam logic [15:0]        CLICK_WINDOW_RESET = 16'd400;
    localparam logic [15:0]        LONG_PRESS_RESET   = 16'd800;
    localparam logic [CLICK_W-1:0] MAX_CLICKS_RESET   = 4'd3;
    localparam logic [CLICK_W-1:0] CLICKS_SAT         = 4'd15;

    typedef struct packed {
        logic [15:0]        debounce_ms;
        logic [15:0]        click_window_ms;
        logic [15:0]        long_press_ms;
        logic [CLICK_W-1:0] max_clicks;
    } cfg_t;

endpackage

// File: hw/rtl/bcld_cfg_regs.sv
// Configuration register file of the button detector.
// Plain write port, no read-back. Depends on bcld_pkg.
module bcld_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  bcld_pkg::cfg_index_t        cfg_index,
    input  logic [bcld_pkg::CFG_DATA_W-1:0] cfg_data,
    output bcld_pkg::cfg_t              cfg
);
    import bcld_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE:     cfg_next.debounce_ms     = cfg_data;
                CFG_CLICK_WINDOW: cfg_next.click_window_ms = cfg_data;
                CFG_LONG_PRESS:   cfg_next.long_press_ms   = cfg_data;
                CFG_MAX_CLICKS:   cfg_next.max_clicks      = cfg_data[CLICK_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms     <= DEBOUNCE_RESET;
            cfg_reg.click_window_ms <= CLICK_WINDOW_RESET;
            cfg_reg.long_press_ms   <= LONG_PRESS_RESET;
            cfg_reg.max_clicks      <= MAX_CLICKS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/bcld_fsm.sv
// Detector state machine: mode, previous mode, start time and click count.
// Advances by one item per step and computes that item's event. Depends on bcld_pkg.
module bcld_fsm (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic                         pressed,
    input  logic [bcld_pkg::TIME_W-1:0]  now_ms,
    input  bcld_pkg::cfg_t               cfg,
    output bcld_pkg::event_t             event_res,
    output logic [bcld_pkg::CLICK_W-1:0] click_count
);
    import bcld_pkg::*;

    mode_t               mode_reg, mode_next;
    mode_t               prev_reg, prev_next;
    logic [TIME_W-1:0]   start_reg, start_next;
    logic [CLICK_W-1:0]  clicks_reg, clicks_next;

    logic [TIME_W-1:0]   wait_ms;
    logic                short_w;
    logic                long_w;
    logic                seq_done;

    // Elapsed time wraps modulo 2^32.
    assign wait_ms  = now_ms - start_reg;
    assign short_w  = wait_ms < {16'd0, cfg.debounce_ms};
    assign long_w   = wait_ms > {16'd0, cfg.long_press_ms};
    assign seq_done = (wait_ms > {16'd0, cfg.click_window_ms}) ||
                      (clicks_reg == cfg.max_clicks);

    // Next state.
    always_comb
    begin
        mode_next   = mode_reg;
        prev_next   = prev_reg;
        start_next  = start_reg;
        clicks_next = clicks_reg;
        unique case (mode_reg)
            MODE_IDLE:
            begin
                if (pressed)
                begin
                    mode_next   = MODE_DOWN;
                    prev_next   = mode_reg;
                    start_next  = now_ms;
                    clicks_next = '0;
                end
            end
            MODE_DOWN:
            begin
                priority if (!pressed && short_w)
                begin
                    mode_next = prev_reg;
                    prev_next = mode_reg;
                end
                else if (!pressed)
                begin
                    mode_next  = MODE_UP;
                    prev_next  = mode_reg;
                    start_next = now_ms;
                end
                else if (long_w)
                begin
                    mode_next = MODE_PRESS;
                    prev_next = mode_reg;
                end
            end
            MODE_UP:
            begin
                priority if (pressed && short_w)
                begin
                    mode_next = prev_reg;
                    prev_next = mode_reg;
                end
                else if (!short_w)
                begin
                    if (clicks_reg != CLICKS_SAT)
                        clicks_next = clicks_reg + 1'b1;
                    mode_next = MODE_COUNT;
                    prev_next = mode_reg;
                end
            end
            MODE_COUNT:
            begin
                priority if (pressed)
                begin
                    mode_next  = MODE_DOWN;
                    prev_next  = mode_reg;
                    start_next = now_ms;
                end
                else if (seq_done)
                begin
                    mode_next   = MODE_IDLE;
                    prev_next   = MODE_IDLE;
                    start_next  = '0;
                    clicks_next = '0;
                end
            end
            MODE_PRESS:
            begin
                if (!pressed)
                begin
                    mode_next  = MODE_PRESS_END;
                    prev_next  = mode_reg;
                    start_next = now_ms;
                end
            end
            MODE_PRESS_END:
            begin
                priority if (pressed && short_w)
                begin
                    mode_next = prev_reg;
                    prev_next = mode_reg;
                end
                else if (!short_w)
                begin
                    mode_next   = MODE_IDLE;
                    prev_next   = MODE_IDLE;
                    start_next  = '0;
                    clicks_next = '0;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
                prev_next = mode_reg;
            end
        endcase
    end

    // Event and reported count.
    always_comb
    begin
        event_res = EV_NONE;
        unique case (mode_reg)
            MODE_DOWN:
                if (pressed && long_w)
                    event_res = EV_LSTART;
            MODE_COUNT:
                if (!pressed && seq_done)
                begin
                    if (clicks_reg == 4'd1)
                        event_res = EV_SINGLE;
                    else if (clicks_reg == 4'd2)
                        event_res = EV_DOUBLE;
                    else
                        event_res = EV_MULTI;
                end
            MODE_PRESS:
                if (pressed)
                    event_res = EV_DURING;
            MODE_PRESS_END:
                if (!short_w)
                    event_res = EV_LSTOP;
            default:
                event_res = EV_NONE;
        endcase
        // A finished sequence reports its count before the clear.
        if (event_res == EV_SINGLE || event_res == EV_DOUBLE ||
            event_res == EV_MULTI || event_res == EV_LSTOP)
            click_count = clicks_reg;
        else
            click_count = clicks_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            prev_reg   <= MODE_IDLE;
            start_reg  <= '0;
            clicks_reg <= '0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            prev_reg   <= prev_next;
            start_reg  <= start_next;
            clicks_reg <= clicks_next;
        end
    end

endmodule

// File: hw/rtl/button_click_longpress_detector.sv
// Top level of the button click and long-press detector.
// Input register, detector state machine, result register. Depends on bcld_pkg,
// bcld_cfg_regs and bcld_fsm.
//
// Usage: each input item is one scan tick (pressed level and millisecond
// timestamp) offered with in_valid; it is taken at a rising edge where
// in_valid is high and in_stall is low. Every item yields exactly one result
// item (event_res, click_count) on out_valid, taken where out_stall is low.
// An item taken is registered in the input register, processed by the state
// machine and then held in the result register. Throughput is one item per
// cycle while out_stall is low; the state update is a single compare and add
// stage between the input and result registers.
// When the receiver stalls, the result register holds its item and the input
// register holds one more; in_stall rises only when both are full.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect once
// registered; the user makes them while no item is in flight, unenforced here.
// Reset clears all valid flags, returns the detector to idle with no clicks
// and start time zero, and loads the default register values.
module button_click_longpress_detector (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         pressed,
    input  logic [31:0]                  now_ms,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   event_res,
    output logic [3:0]                   click_count,
    input  logic                         cfg_wr_en,
    input  logic [1:0]                   cfg_index,
    input  logic [15:0]                  cfg_data
);
    import bcld_pkg::*;

    cfg_t                cfg;
    event_t              ev;
    logic [CLICK_W-1:0]  count;

    logic                s1_valid_reg, s1_valid_next;
    logic                s1_pressed_reg;
    logic [TIME_W-1:0]   s1_now_reg;
    logic                out_valid_reg, out_valid_next;
    event_t              out_event_reg;
    logic [CLICK_W-1:0]  out_count_reg;

    logic                in_take;
    logic                advance;

    bcld_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bcld_fsm u_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .pressed     (s1_pressed_reg),
        .now_ms      (s1_now_reg),
        .cfg         (cfg),
        .event_res   (ev),
        .click_count (count)
    );

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_pressed_reg <= pressed;
            s1_now_reg     <= now_ms;
        end
        if (advance)
        begin
            out_event_reg <= ev;
            out_count_reg <= count;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_res   = out_event_reg;
    assign click_count = out_count_reg;

endmodule
